/* rtl/y4m_pkg.sv */
// Package for the y4m header parser: byte classes, parse phases, status codes.
// No dependencies.
package y4m_pkg;
	localparam int LineLimitDefault = 80;
	localparam int SkipPrefixDefault = 10;

	typedef enum logic [3:0] {
		PH_TAG, PH_SKIP, PH_W, PH_H, PH_F1, PH_F2, PH_A1, PH_A2, PH_I, PH_COLOUR
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EOF = 3'd1, ST_ZERO = 3'd2, ST_COLOUR = 3'd3, ST_INTER = 3'd4
	} status_t;

	// front to back queue entry
	typedef struct packed {
		logic       eoi;     // end of input
		logic       parse;   // byte is past the prefix
		logic       last;    // line ends with this item
		logic       nl;      // byte is newline (not parsed)
		logic [7:0] data;
	} cmd_t;
endpackage

/* rtl/y4m_header_parser.sv */
// Header line parser for a raw video stream, top level.
// Usage:
//  Input channel (in_valid/in_ready): one byte per item in data_byte, or
//  end_of_input = 1 to flag stream end (data ignored, result status 1).
//  Output channel (out_valid/out_ready): one result per line, at a newline,
//  at byte LINE_LIMIT-1 of the line, or at end of input. Other items give
//  no result. The first SKIP_PREFIX bytes of a line are not parsed.
//  Throughput: one item per cycle while the receiver does not stall; the back end
//  does one multiply-by-ten accumulate per digit byte.
//  A line-ending item goes through a queue entry, then the result register,
//  before its result shows.
//  Reset clears position, parse state, queue and output valid.
//  When the receiver stalls, the result register holds, the two-entry queue
//  fills, then in_ready drops.
// Depends on y4m_pkg, y4m_front, y4m_queue, y4m_back.
module y4m_header_parser import y4m_pkg::*; #(
	parameter int LINE_LIMIT = LineLimitDefault,
	parameter int SKIP_PREFIX = SkipPrefixDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] pic_width,
	output logic [15:0] pic_height,
	output logic [31:0] rate_num,
	output logic [31:0] rate_den,
	output logic [3:0]  bit_depth,
	output logic [2:0]  chroma_format
);
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t fq_cmd, qb_cmd;

	y4m_front #(.LINE_LIMIT(LINE_LIMIT), .SKIP_PREFIX(SKIP_PREFIX)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .end_of_input,
		.cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
	);

	y4m_queue u_queue (
		.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
	);

	y4m_back u_back (
		.clk, .arst_n, .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
		.out_valid, .out_ready, .status, .pic_width, .pic_height, .rate_num,
		.rate_den, .bit_depth, .chroma_format
	);

`ifndef SYNTHESIS
	a_eof_status: assert property (@(posedge clk) disable iff (!arst_n)
		qb_valid && qb_ready && qb_cmd.eoi |=> out_valid && status == ST_EOF)
		else $error("end of input without status 1");
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		qb_valid && qb_ready && qb_cmd.last |=> out_valid)
		else $error("line end without result");
	a_nolast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
`endif
endmodule

/* rtl/y4m_front.sv */
// Front: accepts bytes, tracks line position, classifies each item.
// Depends on y4m_pkg.
module y4m_front import y4m_pkg::*; #(
	parameter int LINE_LIMIT = LineLimitDefault,
	parameter int SKIP_PREFIX = SkipPrefixDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);
	localparam int PW = $clog2(LINE_LIMIT);
	logic [PW-1:0] pos_q;
	logic          nl, acc;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign acc       = in_valid && cmd_ready;
	assign nl        = data_byte == 8'h0A;

	always_comb begin
		cmd.eoi   = end_of_input;
		cmd.nl    = nl;
		cmd.data  = data_byte;
		cmd.parse = !nl && (32'(pos_q) >= 32'(SKIP_PREFIX));
		cmd.last  = end_of_input || nl || (32'(pos_q) >= 32'(LINE_LIMIT - 2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			if (cmd.last) pos_q <= '0;
			else pos_q <= pos_q + 1'b1;
		end
	end
endmodule

/* rtl/y4m_queue.sv */
// Two-entry queue between front and back.
// Depends on y4m_pkg.
module y4m_queue import y4m_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);
	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

/* rtl/y4m_back.sv */
// Back: tag parser, number accumulate, colour match, result register.
// Depends on y4m_pkg.
module y4m_back import y4m_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] pic_width,
	output logic [15:0] pic_height,
	output logic [31:0] rate_num,
	output logic [31:0] rate_den,
	output logic [3:0]  bit_depth,
	output logic [2:0]  chroma_format
);
	phase_t      ph_q, ph_d;
	logic [31:0] acc_q, acc_d;
	logic [3:0]  cm_q, cm_d, dep_q, dep_d;
	logic [15:0] w_q, w_d, h_q, h_d;
	logic [31:0] num_q, num_d, den_q, den_d;
	logic [2:0]  fmt_q, fmt_d;
	logic        ie_q, ie_d;
	logic        go, isdig;
	logic [35:0] prod;
	logic [31:0] accn;
	logic [7:0]  c;
	status_t     st;

	assign cmd_ready = !out_valid || out_ready;
	assign go        = cmd_valid && cmd_ready;
	assign c         = cmd.data;
	assign isdig     = c >= "0" && c <= "9";
	assign prod      = {4'd0, acc_q} * 36'd10 + {32'd0, c[3:0]};
	assign accn      = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic phase_t tagph(input logic [7:0] b);
		case (b)
			" ":     return PH_TAG;
			"W":     return PH_W;
			"H":     return PH_H;
			"F":     return PH_F1;
			"A":     return PH_A1;
			"I":     return PH_I;
			"C":     return PH_COLOUR;
			default: return PH_SKIP;
		endcase
	endfunction

	always_comb begin
		logic fail;
		fail = 1'b0;
		ph_d = ph_q; acc_d = acc_q; cm_d = cm_q; dep_d = dep_q;
		w_d = w_q; h_d = h_q; num_d = num_q; den_d = den_q; fmt_d = fmt_q; ie_d = ie_q;
		if (cmd.parse) begin
			case (ph_q)
				PH_TAG: begin
					acc_d = '0; cm_d = '0; ph_d = tagph(c);
				end
				PH_W, PH_H, PH_F2, PH_A2: begin
					if (isdig) acc_d = accn;
					else begin
						if (ph_q == PH_W) w_d = sat16(acc_q);
						else if (ph_q == PH_H) h_d = sat16(acc_q);
						else if (ph_q == PH_F2) den_d = acc_q;
						acc_d = '0; cm_d = '0; ph_d = tagph(c);
					end
				end
				PH_F1, PH_A1: begin
					if (isdig) acc_d = accn;
					else begin
						if (ph_q == PH_F1) begin
							num_d = acc_q; ph_d = PH_F2;
						end else ph_d = PH_A2;
						acc_d = '0;
					end
				end
				PH_I: begin
					if (c != "p") ie_d = 1'b1;
					ph_d = PH_TAG;
				end
				PH_COLOUR: begin
					case (cm_q)
						4'd0: begin
							if (c == "4") cm_d = 4'd1;
							else if (c == "m") cm_d = 4'd4;
							else begin
								fmt_d = '0; acc_d = '0; ph_d = tagph(c);
							end
						end
						4'd1: begin
							if (c == "2") cm_d = 4'd2;
							else if (c == "4") cm_d = 4'd3;
							else fail = 1'b1;
						end
						4'd2: begin
							if (c == "0") begin
								fmt_d = 3'd2; dep_d = 4'd8; cm_d = 4'd7;
							end else if (c == "2") begin
								fmt_d = 3'd3; dep_d = 4'd8; cm_d = 4'd7;
							end else fail = 1'b1;
						end
						4'd3: begin
							if (c == "4") begin
								fmt_d = 3'd4; dep_d = 4'd8; cm_d = 4'd7;
							end else fail = 1'b1;
						end
						4'd4: begin
							if (c == "o") cm_d = 4'd5; else fail = 1'b1;
						end
						4'd5: begin
							if (c == "n") cm_d = 4'd6; else fail = 1'b1;
						end
						4'd6: begin
							if (c == "o") begin
								fmt_d = 3'd1; dep_d = 4'd8; ph_d = PH_SKIP;
							end else fail = 1'b1;
						end
						4'd7: begin
							if (c == "p") cm_d = 4'd8;
							else ph_d = (c == " ") ? PH_TAG : PH_SKIP;
						end
						4'd8: begin
							if (c == "1") cm_d = 4'd9;
							else ph_d = (c == " ") ? PH_TAG : PH_SKIP;
						end
						4'd9: begin
							if (c == "0") begin
								dep_d = 4'd10; ph_d = PH_SKIP;
							end else if (c == "2") begin
								dep_d = 4'd12; ph_d = PH_SKIP;
							end else ph_d = (c == " ") ? PH_TAG : PH_SKIP;
						end
						default: ph_d = (c == " ") ? PH_TAG : PH_SKIP;
					endcase
					if (fail) begin
						fmt_d = '0; ph_d = (c == " ") ? PH_TAG : PH_SKIP;
					end
				end
				default: ph_d = (c == " ") ? PH_TAG : PH_SKIP;
			endcase
		end
		if (cmd.last) begin
			case (ph_d)
				PH_W:      w_d = sat16(acc_d);
				PH_H:      h_d = sat16(acc_d);
				PH_F1:     num_d = acc_d;
				PH_F2:     den_d = acc_d;
				PH_I:      ie_d = 1'b1;
				PH_COLOUR: if (cm_d < 4'd7) fmt_d = '0;
				default:   ;
			endcase
		end
		if (cmd.eoi) st = ST_EOF;
		else if (ie_d) st = ST_INTER;
		else if (w_d == '0 || h_d == '0) st = ST_ZERO;
		else if (dep_d == '0 || fmt_d == '0) st = ST_COLOUR;
		else st = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_TAG; acc_q <= '0; cm_q <= '0; dep_q <= '0; w_q <= '0; h_q <= '0;
			num_q <= '0; den_q <= '0; fmt_q <= '0; ie_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (go) begin
				if (cmd.last) begin
					out_valid <= 1'b1;
					ph_q <= PH_TAG; acc_q <= '0; cm_q <= '0; dep_q <= '0; w_q <= '0;
					h_q <= '0; num_q <= '0; den_q <= '0; fmt_q <= '0; ie_q <= 1'b0;
				end else begin
					ph_q <= ph_d; acc_q <= acc_d; cm_q <= cm_d; dep_q <= dep_d; w_q <= w_d;
					h_q <= h_d; num_q <= num_d; den_q <= den_d; fmt_q <= fmt_d; ie_q <= ie_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && cmd.last) begin
			status <= st;
			pic_width     <= cmd.eoi ? '0 : w_d;
			pic_height    <= cmd.eoi ? '0 : h_d;
			rate_num      <= cmd.eoi ? '0 : num_d;
			rate_den      <= cmd.eoi ? '0 : den_d;
			bit_depth     <= cmd.eoi ? '0 : dep_d;
			chroma_format <= cmd.eoi ? '0 : fmt_d;
		end
	end
endmodule

/* test/tb_y4m_header_parser.sv */
// Testbench for y4m_header_parser: drives header bytes and end-of-input items,
// predicts each result with an internal line parser model and checks it.
// Depends on y4m_pkg and the y4m_header_parser RTL.
`timescale 1ns / 1ps
module tb_y4m_header_parser;
	import y4m_pkg::*;

	localparam int LINE_LIMIT = 80;
	localparam int SKIP_PREFIX = 10;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam byte NL = 8'h0a;

	typedef struct {
		status_t     st;
		logic [15:0] w;
		logic [15:0] h;
		logic [31:0] num;
		logic [31:0] den;
		logic [3:0]  depth;
		logic [2:0]  fmt;
	} header_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [15:0] pic_width;
	logic [15:0] pic_height;
	logic [31:0] rate_num;
	logic [31:0] rate_den;
	logic [3:0]  bit_depth;
	logic [2:0]  chroma_format;

	y4m_header_parser #(.LINE_LIMIT(LINE_LIMIT), .SKIP_PREFIX(SKIP_PREFIX)) dut (.*);

	always #4 clk = ~clk;

	header_t  headers_pending[$];
	int       error_count = 0;
	int       idle_cycles = 0;
	bit       calm = 1'b0;
	bit       hold_off = 1'b0;
	int       hold_cycles = 0;

	// line parser model state
	int          pos;
	phase_t      phase;
	logic [31:0] acc;
	int          cprog;
	logic [15:0] w_v, h_v;
	logic [31:0] num_v, den_v;
	logic [3:0]  depth_v;
	logic [2:0]  fmt_v;
	bit          ierr;

	function automatic void line_clear();
		pos = 0; phase = PH_TAG; acc = 0; cprog = 0;
		w_v = 0; h_v = 0; num_v = 0; den_v = 0; depth_v = 0; fmt_v = 0; ierr = 0;
	endfunction

	function automatic logic [15:0] clip16(logic [31:0] v);
		return (v > 32'd65535) ? 16'hffff : v[15:0];
	endfunction

	function automatic void add_digit(byte unsigned c);
		logic [63:0] t;
		t = {32'd0, acc} * 64'd10 + 64'(c - 8'h30);
		acc = (t > 64'hffffffff) ? 32'hffffffff : t[31:0];
	endfunction

	function automatic void begin_tag(byte unsigned c);
		acc = 0; cprog = 0;
		case (c)
			" ": phase = PH_TAG;
			"W": phase = PH_W;
			"H": phase = PH_H;
			"F": phase = PH_F1;
			"A": phase = PH_A1;
			"I": phase = PH_I;
			"C": phase = PH_COLOUR;
			default: phase = PH_SKIP;
		endcase
	endfunction

	function automatic void skip_to_space(byte unsigned c);
		phase = (c == " ") ? PH_TAG : PH_SKIP;
	endfunction

	function automatic void colour_found(logic [2:0] f);
		fmt_v = f; depth_v = 8; cprog = 7;
	endfunction

	function automatic void colour_step(byte unsigned c);
		bit bad;
		bad = 0;
		case (cprog)
			0: begin
				if (c == "4") cprog = 1;
				else if (c == "m") cprog = 4;
				else begin
					fmt_v = 0; begin_tag(c);
				end
				return;
			end
			1: if (c == "2") cprog = 2; else if (c == "4") cprog = 3; else bad = 1;
			2: if (c == "0") colour_found(2); else if (c == "2") colour_found(3); else bad = 1;
			3: if (c == "4") colour_found(4); else bad = 1;
			4: if (c == "o") cprog = 5; else bad = 1;
			5: if (c == "n") cprog = 6; else bad = 1;
			6: begin
				if (c == "o") begin
					fmt_v = 1; depth_v = 8; phase = PH_SKIP;
				end else bad = 1;
			end
			7: if (c == "p") cprog = 8; else skip_to_space(c);
			8: if (c == "1") cprog = 9; else skip_to_space(c);
			9: begin
				if (c == "0") begin
					depth_v = 10; phase = PH_SKIP;
				end else if (c == "2") begin
					depth_v = 12; phase = PH_SKIP;
				end else skip_to_space(c);
			end
			default: skip_to_space(c);
		endcase
		if (bad) begin
			fmt_v = 0; skip_to_space(c);
		end
	endfunction

	function automatic void parse_char(byte unsigned c);
		bit dig;
		dig = (c >= "0" && c <= "9");
		case (phase)
			PH_TAG: begin_tag(c);
			PH_W, PH_H, PH_F2, PH_A2: begin
				if (dig) add_digit(c);
				else begin
					if (phase == PH_W) w_v = clip16(acc);
					else if (phase == PH_H) h_v = clip16(acc);
					else if (phase == PH_F2) den_v = acc;
					begin_tag(c);
				end
			end
			PH_F1, PH_A1: begin
				if (dig) add_digit(c);
				else begin
					if (phase == PH_F1) begin
						num_v = acc; phase = PH_F2;
					end else phase = PH_A2;
					acc = 0;
				end
			end
			PH_I: begin
				if (c != "p") ierr = 1;
				phase = PH_TAG;
			end
			PH_COLOUR: colour_step(c);
			default: skip_to_space(c);
		endcase
	endfunction

	function automatic void header_predict(byte unsigned c, bit eoi);
		header_t r;
		if (eoi) begin
			r = '{ST_EOF, 0, 0, 0, 0, 0, 0};
			headers_pending.push_back(r);
			line_clear();
			return;
		end
		if (c != NL) begin
			if (pos >= SKIP_PREFIX) parse_char(c);
			if (pos < LINE_LIMIT - 2) begin
				pos++;
				return;
			end
		end
		case (phase)
			PH_W: w_v = clip16(acc);
			PH_H: h_v = clip16(acc);
			PH_F1: num_v = acc;
			PH_F2: den_v = acc;
			PH_I: ierr = 1;
			PH_COLOUR: if (cprog < 7) fmt_v = 0;
			default: ;
		endcase
		if (ierr) r.st = ST_INTER;
		else if (w_v == 0 || h_v == 0) r.st = ST_ZERO;
		else if (depth_v == 0 || fmt_v == 0) r.st = ST_COLOUR;
		else r.st = ST_OK;
		r.w = w_v; r.h = h_v; r.num = num_v; r.den = den_v; r.depth = depth_v; r.fmt = fmt_v;
		headers_pending.push_back(r);
		line_clear();
	endfunction

	// send one item; inputs change on the falling edge
	task automatic send_item(byte unsigned c, bit eoi = 0);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		data_byte <= c;
		end_of_input <= eoi;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		header_predict(c, eoi);
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_item(s[i]);
	endtask

	task automatic send_line(string tags);
		send_text({"YUV4MPEG2 ", tags, "\n"});
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (hold_off || headers_pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic string random_number();
		int n;
		string s;
		n = $urandom_range(99);
		if (n < 5) return "";
		if (n < 15) begin
			s = "";
			repeat ($urandom_range(12, 6)) s = {s, string'(byte'("0" + $urandom_range(9)))};
			return s;
		end
		return $sformatf("%0d", $urandom_range(n < 20 ? 0 : 1, n < 60 ? 4096 : 99999));
	endfunction

	function automatic string random_tag();
		string codes[] = '{"420", "422", "444", "mono", "420p10", "422p12", "444p10",
			"420jpeg", "444alpha", "42", "4x", "mon", "mx", "x", "420p1", "422p9", ""};
		case ($urandom_range(9))
			0: return {"W", random_number()};
			1: return {"H", random_number()};
			2: return {"F", random_number(), ":", random_number()};
			3: return {"A", random_number(), ":", random_number()};
			4: return ($urandom_range(9) < 8) ? "Ip" : "Ii";
			5, 6: return {"C", codes[$urandom_range(codes.size() - 1)]};
			7: return {"X", random_number()};
			8: return "";
			default: return {"W", random_number(), " H", random_number()};
		endcase
	endfunction

	task automatic test_directed();
		send_line("W1920 H1080 F30000:1001 Ip A1:1 C420p10");
		send_line("W0 H65536 F4294967296:99999999999 C444p12");
		send_line("W352 H288 Ii Cmono");
		send_line("W4 H4 Cmonx I");
		send_item(8'h00);
		send_item(8'hff);
		send_item(8'd1, 1'b1);
		send_text("YUV\n");
		send_item(8'h00, 1'b1);
		send_text("YUV4MPEG2 W16 H16 F2:1 C422p12xyz A9");
		repeat (60) send_item("1");
		send_line("W8 H8 Cx H9 C4 Q7 F:");
	endtask

	task automatic test_random(int count);
		int sent;
		string s;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 85) begin
				s = "YUV4MPEG2 ";
				repeat ($urandom_range(8, 1)) s = {s, random_tag(), " "};
				s = {s, random_tag()};
				if ($urandom_range(99) < 10) s = s.substr(0, $urandom_range(s.len() - 1));
				if (s.len() > 85) s = s.substr(0, 84);
				send_text(s);
				sent += s.len();
				if ($urandom_range(99) < 3) send_item(8'($urandom_range(255)), 1'b1);
				else if (s.len() < LINE_LIMIT - 1) send_item(NL);
				sent++;
			end else begin
				repeat ($urandom_range(30, 1)) begin
					send_item(8'($urandom_range(255)), $urandom_range(99) < 2);
					sent++;
				end
			end
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 60;
		hold_off = 1'b1;
		send_line("W640 H480 Ip C444");
		send_line("W1 H1 Cmono");
		wait_drained();
		send_line("W7 H7 C422p10");
		wait_drained();
	endtask

	task automatic test_calm();
		calm = 1'b1;
		test_random(150);
		calm = 1'b0;
	endtask

	// receiver
	always @(negedge clk) begin
		if (hold_off) begin
			out_ready <= 1'b0;
			if (hold_cycles == 0) hold_off <= 1'b0;
			else hold_cycles <= hold_cycles - 1;
		end else out_ready <= calm || ($urandom_range(99) >= 7);
	end

	// checker
	always @(posedge clk) begin
		header_t e;
		if (arst_n && out_valid && out_ready) begin
			if (headers_pending.size() == 0) begin
				$error("unexpected result, status %0d", status);
				error_count++;
			end else begin
				e = headers_pending.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status); error_count++;
				end
				if (pic_width !== e.w) begin
					$error("pic_width: expected %0d, got %0d", e.w, pic_width); error_count++;
				end
				if (pic_height !== e.h) begin
					$error("pic_height: expected %0d, got %0d", e.h, pic_height); error_count++;
				end
				if (rate_num !== e.num) begin
					$error("rate_num: expected %0d, got %0d", e.num, rate_num); error_count++;
				end
				if (rate_den !== e.den) begin
					$error("rate_den: expected %0d, got %0d", e.den, rate_den); error_count++;
				end
				if (bit_depth !== e.depth) begin
					$error("bit_depth: expected %0d, got %0d", e.depth, bit_depth); error_count++;
				end
				if (chroma_format !== e.fmt) begin
					$error("chroma_format: expected %0d, got %0d", e.fmt, chroma_format);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		line_clear();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_calm();
		test_random(750);
		wait_drained();
		repeat (10) @(negedge clk);
		if (error_count == 0 && headers_pending.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
